@@ sv/stws_pkg.sv @@
package stws_pkg;

    localparam int DEF_STAGES       = 14;
    localparam int DEF_WINDOW_DEPTH = 256;

    localparam int FUNC_W   = 2;
    localparam int STAGE_W  = 4;
    localparam int STAMP_W  = 48;
    localparam int TIME_W   = 32;
    localparam int FRAMES_W = 9;

    localparam logic [FUNC_W-1:0] FUNC_BEGIN   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_END     = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_ADVANCE = 2'd2;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [STAGE_W-1:0] stage;
        logic [STAMP_W-1:0] timestamp_us;
    } in_item_t;

    typedef struct packed {
        logic [TIME_W-1:0]   average_us;
        logic [TIME_W-1:0]   maximum_us;
        logic [TIME_W-1:0]   previous_us;
        logic [FRAMES_W-1:0] frames_counted;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_END_CALC,
        ST_END_WR,
        ST_RSTART,
        ST_WALK,
        ST_PREV,
        ST_PREV_WAIT,
        ST_DIV,
        ST_OUT
    } state_t;

endpackage

@@ sv/stws_ram.sv @@
module stws_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

@@ sv/stws_div.sv @@
module stws_div #(
    parameter int DVD_W = 41,
    parameter int DVS_W = 9
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DVD_W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [DVS_W:0]   trial;

    // restoring division, one quotient bit per cycle
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        trial     = {rem_reg, quo_reg[DVD_W-1]};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next = DVS_W'(trial - {1'b0, dvs_reg});
                quo_next = {quo_reg[DVD_W-2:0], 1'b1};
            end else begin
                rem_next = DVS_W'(trial);
                quo_next = {quo_reg[DVD_W-2:0], 1'b0};
            end
            cnt_next = CNT_W'(cnt_reg + 1'b1);
            if (cnt_reg == CNT_W'(DVD_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ sv/stage_timing_window_stats.sv @@
// stage timing window statistics
// input channel s_valid/s_ready/s_data carries begin, end and advance events
// for a stage; every accepted transaction yields exactly one result on
// m_valid/m_ready/m_data with the mean, maximum and previous-frame time of
// the named stage over the counted frames, plus the frame count.
// all per-stage frame times live in one synchronous ram of
// STAGES*WINDOW_DEPTH words; start stamps live in a small second ram.
// each transaction runs an update step, then walks the counted frame
// words in the ram (one read per cycle) and fetches the previous slot,
// then runs a bit-serial division and loads the output register; when
// the stage is out of range or no frame is counted yet, the walk and
// the division are skipped. the block then returns to idle, where the
// next transaction is accepted.
// s_ready is high only between transactions; a finished result sits in the
// output register while the next transaction is accepted, and if the
// receiver still stalls when the next result is done, that result waits.
// after reset all STAGES*WINDOW_DEPTH words of the frame ram (3584 by
// default) are cleared, one word per cycle, with s_ready held low.
module stage_timing_window_stats #(
    parameter int STAGES       = stws_pkg::DEF_STAGES,
    parameter int WINDOW_DEPTH = stws_pkg::DEF_WINDOW_DEPTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  stws_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output stws_pkg::out_item_t m_data
);

    localparam int TIME_W    = stws_pkg::TIME_W;
    localparam int STAMP_W   = stws_pkg::STAMP_W;
    localparam int FRAMES_W  = stws_pkg::FRAMES_W;
    localparam int MEM_DEPTH = STAGES * WINDOW_DEPTH;
    localparam int MAW       = $clog2(MEM_DEPTH);
    localparam int SAW       = (STAGES > 1) ? $clog2(STAGES) : 1;
    localparam int PW        = $clog2(WINDOW_DEPTH);
    localparam int CW        = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W     = TIME_W + CW;

    stws_pkg::state_t    state_reg, state_next;
    stws_pkg::in_item_t  item_reg, item_next;
    stws_pkg::out_item_t out_reg, out_next;

    logic              m_valid_reg, m_valid_next;
    logic              in_range_reg, in_range_next;
    logic [MAW-1:0]    base_reg, base_next;
    logic [MAW-1:0]    clr_reg, clr_next;
    logic [PW-1:0]     pos_reg, pos_next;
    logic [CW-1:0]     total_reg, total_next;
    logic [PW-1:0]     idx_reg, idx_next;
    logic              rd_pend_reg, rd_pend_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [TIME_W-1:0] top_reg, top_next;
    logic [TIME_W-1:0] prev_reg, prev_next;
    logic [TIME_W-1:0] avg_reg, avg_next;
    logic [TIME_W-1:0] elapsed_reg, elapsed_next;
    logic [STAGES-1:0] stamp_vld_reg, stamp_vld_next;
    logic              stamp_hit_reg, stamp_hit_next;

    logic               st_we;
    logic [MAW-1:0]     st_waddr;
    logic [TIME_W-1:0]  st_wdata;
    logic [MAW-1:0]     st_raddr;
    logic [TIME_W-1:0]  st_rdata;
    logic               sp_we;
    logic [SAW-1:0]     sp_addr;
    logic [STAMP_W-1:0] sp_rdata;
    logic [STAMP_W-1:0] stamp_val;
    logic [STAMP_W-1:0] diff;
    logic [PW-1:0]      prev_slot;
    logic               walk_last;
    logic               out_load;
    logic               div_start;
    logic               div_done;
    logic [SUM_W-1:0]   div_quo;

    stws_ram #(
        .WIDTH (TIME_W),
        .DEPTH (MEM_DEPTH),
        .AW    (MAW)
    ) u_store (
        .aclk  (aclk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    stws_ram #(
        .WIDTH (STAMP_W),
        .DEPTH (STAGES),
        .AW    (SAW)
    ) u_stamps (
        .aclk  (aclk),
        .we    (sp_we),
        .waddr (sp_addr),
        .wdata (item_reg.timestamp_us),
        .raddr (sp_addr),
        .rdata (sp_rdata)
    );

    stws_div #(
        .DVD_W (SUM_W),
        .DVS_W (CW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (total_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign sp_addr   = SAW'(item_reg.stage);
    assign prev_slot = (pos_reg == '0) ? PW'(WINDOW_DEPTH - 1) : PW'(pos_reg - 1'b1);
    assign walk_last = (CW'(idx_reg) + CW'(1)) == total_reg;
    assign out_load  = !m_valid_reg || m_ready;
    // a stamp never written reads as zero
    assign stamp_val = stamp_hit_reg ? sp_rdata : '0;
    assign diff      = item_reg.timestamp_us - stamp_val;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            stws_pkg::ST_CLEAR: begin
                if (clr_reg == MAW'(MEM_DEPTH - 1)) begin
                    state_next = stws_pkg::ST_IDLE;
                end
            end
            stws_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = stws_pkg::ST_EXEC;
                end
            end
            stws_pkg::ST_EXEC: begin
                if (item_reg.func == stws_pkg::FUNC_END && in_range_reg) begin
                    state_next = stws_pkg::ST_END_CALC;
                end else begin
                    state_next = stws_pkg::ST_RSTART;
                end
            end
            stws_pkg::ST_END_CALC: state_next = stws_pkg::ST_END_WR;
            stws_pkg::ST_END_WR:   state_next = stws_pkg::ST_RSTART;
            stws_pkg::ST_RSTART: begin
                if (in_range_reg && total_reg != '0) begin
                    state_next = stws_pkg::ST_WALK;
                end else begin
                    state_next = stws_pkg::ST_OUT;
                end
            end
            stws_pkg::ST_WALK: begin
                if (walk_last) begin
                    state_next = stws_pkg::ST_PREV;
                end
            end
            stws_pkg::ST_PREV:      state_next = stws_pkg::ST_PREV_WAIT;
            stws_pkg::ST_PREV_WAIT: state_next = stws_pkg::ST_DIV;
            stws_pkg::ST_DIV: begin
                if (div_done) begin
                    state_next = stws_pkg::ST_OUT;
                end
            end
            stws_pkg::ST_OUT: begin
                if (out_load) begin
                    state_next = stws_pkg::ST_IDLE;
                end
            end
            default: state_next = stws_pkg::ST_CLEAR;
        endcase
    end

    always_comb begin
        item_next      = item_reg;
        out_next       = out_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        in_range_next  = in_range_reg;
        base_next      = base_reg;
        clr_next       = clr_reg;
        pos_next       = pos_reg;
        total_next     = total_reg;
        idx_next       = idx_reg;
        rd_pend_next   = 1'b0;
        sum_next       = sum_reg;
        top_next       = top_reg;
        prev_next      = prev_reg;
        avg_next       = avg_reg;
        elapsed_next   = elapsed_reg;
        stamp_vld_next = stamp_vld_reg;
        stamp_hit_next = stamp_hit_reg;
        s_ready        = 1'b0;
        st_we          = 1'b0;
        st_waddr       = MAW'(base_reg + MAW'(pos_reg));
        st_wdata       = elapsed_reg;
        st_raddr       = MAW'(base_reg + MAW'(idx_reg));
        sp_we          = 1'b0;
        div_start      = 1'b0;

        // walk read data lands in the cycle after its address is given
        if (rd_pend_reg) begin
            sum_next = SUM_W'(sum_reg + SUM_W'(st_rdata));
            if (st_rdata > top_reg) begin
                top_next = st_rdata;
            end
        end

        unique case (state_reg)
            stws_pkg::ST_CLEAR: begin
                st_we    = 1'b1;
                st_waddr = clr_reg;
                st_wdata = '0;
                clr_next = MAW'(clr_reg + 1'b1);
            end
            stws_pkg::ST_IDLE: begin
                s_ready       = 1'b1;
                item_next     = s_data;
                in_range_next = 32'(s_data.stage) < STAGES;
                base_next     = MAW'(32'(s_data.stage) * WINDOW_DEPTH);
            end
            stws_pkg::ST_EXEC: begin
                stamp_hit_next = stamp_vld_reg[sp_addr];
                if (in_range_reg && item_reg.func == stws_pkg::FUNC_BEGIN) begin
                    sp_we                   = 1'b1;
                    stamp_vld_next[sp_addr] = 1'b1;
                end
                if (item_reg.func == stws_pkg::FUNC_ADVANCE) begin
                    pos_next = (pos_reg == PW'(WINDOW_DEPTH - 1)) ? '0
                                                                  : PW'(pos_reg + 1'b1);
                    if (total_reg != CW'(WINDOW_DEPTH)) begin
                        total_next = CW'(total_reg + 1'b1);
                    end
                end
            end
            stws_pkg::ST_END_CALC: begin
                // saturate the wrapped 48-bit difference to 32 bits
                elapsed_next = (|diff[STAMP_W-1:TIME_W]) ? '1 : diff[TIME_W-1:0];
            end
            stws_pkg::ST_END_WR: begin
                st_we = 1'b1;
            end
            stws_pkg::ST_RSTART: begin
                idx_next  = '0;
                sum_next  = '0;
                top_next  = '0;
                prev_next = '0;
                avg_next  = '0;
            end
            stws_pkg::ST_WALK: begin
                rd_pend_next = 1'b1;
                idx_next     = PW'(idx_reg + 1'b1);
            end
            stws_pkg::ST_PREV: begin
                st_raddr = MAW'(base_reg + MAW'(prev_slot));
            end
            stws_pkg::ST_PREV_WAIT: begin
                prev_next = st_rdata;
                div_start = 1'b1;
            end
            stws_pkg::ST_DIV: begin
                avg_next = div_quo[TIME_W-1:0];
            end
            stws_pkg::ST_OUT: begin
                if (out_load) begin
                    m_valid_next           = 1'b1;
                    out_next.average_us     = avg_reg;
                    out_next.maximum_us     = top_reg;
                    out_next.previous_us    = prev_reg;
                    out_next.frames_counted = FRAMES_W'(total_reg);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= stws_pkg::ST_CLEAR;
            m_valid_reg   <= 1'b0;
            clr_reg       <= '0;
            pos_reg       <= '0;
            total_reg     <= '0;
            rd_pend_reg   <= 1'b0;
            stamp_vld_reg <= '0;
        end else begin
            state_reg     <= state_next;
            m_valid_reg   <= m_valid_next;
            clr_reg       <= clr_next;
            pos_reg       <= pos_next;
            total_reg     <= total_next;
            rd_pend_reg   <= rd_pend_next;
            stamp_vld_reg <= stamp_vld_next;
        end
        item_reg      <= item_next;
        out_reg       <= out_next;
        in_range_reg  <= in_range_next;
        base_reg      <= base_next;
        idx_reg       <= idx_next;
        sum_reg       <= sum_next;
        top_reg       <= top_next;
        prev_reg      <= prev_next;
        avg_reg       <= avg_next;
        elapsed_reg   <= elapsed_next;
        stamp_hit_reg <= stamp_hit_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    a_accept_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == stws_pkg::ST_EXEC))
        else $error("accepted transaction did not start execution");

    a_total_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (total_reg <= CW'(WINDOW_DEPTH)))
        else $error("frame count beyond window depth");

    a_div_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == stws_pkg::ST_DIV))
        else $error("divider finished outside the divide state");

    a_store_write: assert property (@(posedge aclk) disable iff (!aresetn)
        st_we |-> (state_reg == stws_pkg::ST_CLEAR || state_reg == stws_pkg::ST_END_WR))
        else $error("frame ram written outside clear or end update");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid_reg ##1 m_valid_reg) |-> ($past(state_reg) == stws_pkg::ST_OUT))
        else $error("result appeared without passing the output state");

endmodule
